// ===== hdl/rlse_pkg.sv =====
// Shared types and constants for the rainbow LED effect sequencer.
`default_nettype none

package rlse_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SATURATION  = 3'd0;
  localparam logic [2:0] REG_BRIGHTNESS  = 3'd1;
  localparam logic [2:0] REG_HUE_STEP    = 3'd2;
  localparam logic [2:0] REG_WHITE_HOLD  = 3'd3;
  localparam logic [2:0] REG_COLOR_HOLD  = 3'd4;
  localparam logic [2:0] REG_DIM_LEVEL   = 3'd5;

  // Configuration reset values
  localparam logic [7:0] SATURATION_RST  = 8'd255;
  localparam logic [7:0] BRIGHTNESS_RST  = 8'd255;
  localparam logic [8:0] HUE_STEP_RST    = 9'd3;
  localparam logic [7:0] WHITE_HOLD_RST  = 8'd125;
  localparam logic [7:0] COLOR_HOLD_RST  = 8'd25;
  localparam logic [7:0] DIM_LEVEL_RST   = 8'd16;

  // Sequence phases
  localparam logic [2:0] PH_WHITE   = 3'd0;
  localparam logic [2:0] PH_RED     = 3'd1;
  localparam logic [2:0] PH_GREEN   = 3'd2;
  localparam logic [2:0] PH_BLUE    = 3'd3;
  localparam logic [2:0] PH_RAINBOW = 3'd4;

  // Input kinds carried on tuser
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_ENABLE = 1'b1;

  localparam logic [7:0] CHAN_FULL = 8'd255;
  localparam logic [7:0] CHAN_OFF  = 8'd0;

  // Multiplier operand width and digit size
  localparam int unsigned MUL_W     = 8;
  localparam int unsigned DIGIT_W   = 2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_SR,
    S_MUL_SNR,
    S_MUL_P,
    S_MUL_Q,
    S_MUL_T,
    S_EMIT
  } seq_state_t;

  // Request to and response from the serial multiplier
  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] mcand;
    logic [MUL_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MUL_W-1:0] quo;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/rlse_mul_ser.sv =====
// Digit-serial 8x8 multiplier whose result is the product divided by 255.
`default_nettype none

module rlse_mul_ser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rlse_pkg::mul_req_t req,
  output rlse_pkg::mul_rsp_t   rsp
);
  import rlse_pkg::*;

  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned DIGITS  = MUL_W / DIGIT_W;
  localparam int unsigned CNT_W   = $clog2(DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [MUL_W-1:0]  mplier_r, mplier_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] pp;
  logic [PROD_W:0]   div_sum;

  // Partial product of one multiplier digit
  always_comb begin
    pp = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (mplier_r[i]) begin
        pp = pp + (mcand_r << i);
      end
    end
  end

  // Start loads operands, each busy cycle folds in one digit
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (busy_r) begin
      acc_nxt    = acc_r + pp;
      mcand_nxt  = mcand_r << DIGIT_W;
      mplier_nxt = mplier_r >> DIGIT_W;
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(req.mcand);
      mplier_nxt = req.mplier;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  // Exact floor(x / 255) for any product of two 8-bit operands
  assign div_sum  = {1'b0, acc_r} + (PROD_W + 1)'(acc_r >> MUL_W) + 1'b1;
  assign rsp.done = done_r;
  assign rsp.quo  = div_sum[PROD_W-1:MUL_W];

endmodule

`default_nettype wire

// ===== hdl/rainbow_led_effect_sequencer_core.sv =====
// Top level of the rainbow LED effect sequencer: sequencing, HSV conversion and ports.
`default_nettype none

// Each input transaction is either an effect tick (tuser 0) or an enable write
// (tuser 1, new flag in tdata bit 0); at most one RGB transaction leaves per
// input. Enable writes and diagnostic ticks are decided in the accept cycle; writes
// and the first tick of each diagnostic hold reach the output through the S_EMIT
// state and the output register. An enabled rainbow tick runs five products through
// one shared 2-bit-per-cycle multiplier, then takes the same path. The block takes
// one input transaction at a time and accepts the next one as soon as the previous
// result has moved to the output register, even while that register still waits.
// Configuration writes are always taken and must only happen while idle.
module rainbow_led_effect_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] enable_value, [7:1] zero
  input  wire logic        in_tuser,   // [0] func
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [8:0]  cfg_data
);
  import rlse_pkg::*;

  localparam logic [9:0] HUE_FULL   = 10'd360;
  localparam logic [9:0] HUE_DOUBLE = 10'd720;

  seq_state_t state_r, state_nxt;

  // Configuration registers
  logic [7:0] sat_r, bri_r, white_hold_r, color_hold_r, dim_r;
  logic [8:0] hue_step_r;

  // Sequencer state
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] hold_cnt_r, hold_cnt_nxt;
  logic [8:0] hue_r, hue_nxt;
  logic       en_r, en_nxt;

  // Intermediate products and pending color
  logic [7:0] a_r, a_nxt, b_r, b_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [7:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  logic       in_accept, out_free;
  logic       is_diag, first_tick, last_tick;
  logic [7:0] hold_sel, hold_eff;
  logic [2:0] region;
  logic [8:0] region_base;
  logic [5:0] offset;
  logic [9:0] rem_x17;
  logic [7:0] rem;
  logic [9:0] hue_sum;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Diagnostic phase bookkeeping
  assign is_diag    = phase_r < PH_RAINBOW;
  assign hold_sel   = (phase_r == PH_WHITE) ? white_hold_r : color_hold_r;
  assign hold_eff   = (hold_sel == 8'd0) ? 8'd1 : hold_sel;
  assign first_tick = hold_cnt_r == 8'd0;
  assign last_tick  = ({1'b0, hold_cnt_r} + 9'd1) >= {1'b0, hold_eff};

  // Hue region and remainder scaled by 255/60 to 0..250 (x*255/60 equals x*17/4)
  always_comb begin
    if (hue_r >= 9'd300) begin
      region = 3'd5; region_base = 9'd300;
    end else if (hue_r >= 9'd240) begin
      region = 3'd4; region_base = 9'd240;
    end else if (hue_r >= 9'd180) begin
      region = 3'd3; region_base = 9'd180;
    end else if (hue_r >= 9'd120) begin
      region = 3'd2; region_base = 9'd120;
    end else if (hue_r >= 9'd60) begin
      region = 3'd1; region_base = 9'd60;
    end else begin
      region = 3'd0; region_base = 9'd0;
    end
  end

  assign offset  = 6'(hue_r - region_base);
  assign rem_x17 = {offset, 4'b0000} + 10'(offset);
  assign rem     = rem_x17[9:2];
  assign hue_sum = 10'(hue_r) + 10'(hue_step_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_tuser == FUNC_ENABLE) begin
            state_nxt = S_EMIT;
          end else if (is_diag) begin
            state_nxt = first_tick ? S_EMIT : S_IDLE;
          end else if (en_r) begin
            state_nxt = S_MUL_SR;
          end
        end
      end
      S_MUL_SR:  if (mul_rsp.done) state_nxt = S_MUL_SNR;
      S_MUL_SNR: if (mul_rsp.done) state_nxt = S_MUL_P;
      S_MUL_P:   if (mul_rsp.done) state_nxt = S_MUL_Q;
      S_MUL_Q:   if (mul_rsp.done) state_nxt = S_MUL_T;
      S_MUL_T:   if (mul_rsp.done) state_nxt = S_EMIT;
      S_EMIT:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake and multiplier requests
  always_comb begin
    in_tready      = 1'b0;
    mul_req.start  = 1'b0;
    mul_req.mcand  = sat_r;
    mul_req.mplier = rem;
    case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        mul_req.start = in_tvalid && (in_tuser == FUNC_TICK) && !is_diag && en_r;
      end
      S_MUL_SR: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mplier = CHAN_FULL - rem;
      end
      S_MUL_SNR: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = bri_r;
        mul_req.mplier = CHAN_FULL - sat_r;
      end
      S_MUL_P: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = bri_r;
        mul_req.mplier = a_r;
      end
      S_MUL_Q: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = bri_r;
        mul_req.mplier = b_r;
      end
      default: ;
    endcase
  end

  // Datapath updates
  always_comb begin
    phase_nxt     = phase_r;
    hold_cnt_nxt  = hold_cnt_r;
    hue_nxt       = hue_r;
    en_nxt        = en_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    // Take the accepted transaction
    if (in_accept) begin
      if (in_tuser == FUNC_ENABLE) begin
        en_nxt    = in_tdata[0];
        red_nxt   = in_tdata[0] ? dim_r : CHAN_OFF;
        green_nxt = red_nxt;
        blue_nxt  = red_nxt;
      end else if (is_diag) begin
        red_nxt   = (phase_r == PH_WHITE || phase_r == PH_RED)   ? CHAN_FULL : CHAN_OFF;
        green_nxt = (phase_r == PH_WHITE || phase_r == PH_GREEN) ? CHAN_FULL : CHAN_OFF;
        blue_nxt  = (phase_r == PH_WHITE || phase_r == PH_BLUE)  ? CHAN_FULL : CHAN_OFF;
        if (last_tick) begin
          phase_nxt    = phase_r + 3'd1;
          hold_cnt_nxt = 8'd0;
        end else begin
          hold_cnt_nxt = hold_cnt_r + 8'd1;
        end
      end
    end

    // Collect products
    if (mul_rsp.done) begin
      case (state_r)
        S_MUL_SR:  a_nxt = CHAN_FULL - mul_rsp.quo;
        S_MUL_SNR: b_nxt = CHAN_FULL - mul_rsp.quo;
        S_MUL_P:   p_nxt = mul_rsp.quo;
        S_MUL_Q:   q_nxt = mul_rsp.quo;
        S_MUL_T: begin
          // Map v, p, q, t onto channels by region, then advance the hue
          case (region)
            3'd0: begin red_nxt = bri_r; green_nxt = mul_rsp.quo; blue_nxt = p_r; end
            3'd1: begin red_nxt = q_r; green_nxt = bri_r; blue_nxt = p_r; end
            3'd2: begin red_nxt = p_r; green_nxt = bri_r; blue_nxt = mul_rsp.quo; end
            3'd3: begin red_nxt = p_r; green_nxt = q_r; blue_nxt = bri_r; end
            3'd4: begin red_nxt = mul_rsp.quo; green_nxt = p_r; blue_nxt = bri_r; end
            default: begin red_nxt = bri_r; green_nxt = p_r; blue_nxt = q_r; end
          endcase
          if (hue_sum >= HUE_DOUBLE) begin
            hue_nxt = 9'(hue_sum - HUE_DOUBLE);
          end else if (hue_sum >= HUE_FULL) begin
            hue_nxt = 9'(hue_sum - HUE_FULL);
          end else begin
            hue_nxt = 9'(hue_sum);
          end
        end
        default: ;
      endcase
    end

    // Hand the pending color to the output register
    if (state_r == S_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {blue_r, green_r, red_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_WHITE;
      hold_cnt_r  <= 8'd0;
      hue_r       <= 9'd0;
      en_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      hue_r       <= hue_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r        <= SATURATION_RST;
      bri_r        <= BRIGHTNESS_RST;
      hue_step_r   <= HUE_STEP_RST;
      white_hold_r <= WHITE_HOLD_RST;
      color_hold_r <= COLOR_HOLD_RST;
      dim_r        <= DIM_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_SATURATION: sat_r        <= cfg_data[7:0];
        REG_BRIGHTNESS: bri_r        <= cfg_data[7:0];
        REG_HUE_STEP:   hue_step_r   <= cfg_data;
        REG_WHITE_HOLD: white_hold_r <= cfg_data[7:0];
        REG_COLOR_HOLD: color_hold_r <= cfg_data[7:0];
        REG_DIM_LEVEL:  dim_r        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rlse_mul_ser u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Hue stays inside one turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    hue_r < 9'd360)
    else $error("hue out of range");

  // Phase never passes the rainbow phase
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_RAINBOW)
    else $error("phase out of range");

  // Products only come back while a conversion is running
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_MUL_SR || state_r == S_MUL_SNR ||
                      state_r == S_MUL_P || state_r == S_MUL_Q || state_r == S_MUL_T))
    else $error("multiplier done outside conversion");

  // An enable write always leads to a pending result
  a_enable_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_tuser == FUNC_ENABLE) |=> state_r == S_EMIT)
    else $error("enable write did not produce a result");

endmodule

`default_nettype wire
